### rtl/core/sbp_pkg.sv
// shared constants for the shuffle bag picker
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package sbp_pkg;

    localparam int GROUPS_DEF  = 256;
    localparam int SLOTS_DEF   = 32;
    localparam int SWAP_FACTOR = 4;

    localparam int GROUP_W   = 8;
    localparam int SIZE_IN_W = 8;
    localparam int PICK_W    = 5;
    localparam int SEED_W    = 32;

    localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_PICK = 1'b1;

endpackage

`default_nettype wire

### rtl/core/sbp_ifs.sv
// valid/ready channels of the shuffle bag picker: command items in, result items out
// depends on sbp_pkg for field widths
`default_nettype none

interface sbp_cmd_if import sbp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 command;
    logic [GROUP_W-1:0]   group;
    logic [SIZE_IN_W-1:0] size;

    modport source (output valid, output command, output group, output size, input ready);
    modport sink   (input valid, input command, input group, input size, output ready);
endinterface

interface sbp_res_if import sbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PICK_W-1:0] picked;
    logic              error;
    logic              reshuffled;

    modport source (output valid, output picked, output error, output reshuffled, input ready);
    modport sink   (input valid, input picked, input error, input reshuffled, output ready);
endinterface

`default_nettype wire

### rtl/core/shuffle_bag_picker.sv
// shuffle bag picker top level: per-group random picks without replacement
// depends on sbp_pkg and the channel interfaces in sbp_ifs.sv
//
// One command item at a time is worked on; each gives exactly one result item, held in
// an output register so the next item can be taken while the result waits. A pick goes
// through a group table read, an order table read and the result. A set-size of size n
// makes n identity writes, then 4*n swaps, each drawn from the single shared generator
// and done over the read/write ports of the order memory. A pick that finds its group
// used up pays that shuffle as well. After reset a clearing pass over all GROUPS
// entries zeroes the group table before the first item is taken; the seed register
// may be written at any time the block is idle.
`default_nettype none

module shuffle_bag_picker import sbp_pkg::*; #(
    parameter int GROUPS = GROUPS_DEF,
    parameter int SLOTS  = SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [SEED_W-1:0] i_cfg_wdata,
    sbp_cmd_if.sink                i_cmd,
    sbp_res_if.source              o_res
);

    localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SW  = $clog2(SLOTS);
    localparam int ZW  = $clog2(SLOTS + 1);
    localparam int CW  = $clog2(SLOTS * SWAP_FACTOR + 1);
    localparam int OD  = GROUPS * SLOTS;
    localparam int OAW = $clog2(OD);
    localparam int PW  = 16 + ZW;

    typedef struct packed {
        logic [ZW-1:0] size;
        logic [ZW-1:0] count;
    } t_grp_entry;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SET_WR, ST_GRD, ST_GDEC, ST_INIT, ST_DRAW_A, ST_DRAW_B,
        ST_SW_RA, ST_SW_RB, ST_SW_WA, ST_SW_WB, ST_PICK0, ST_ORD_RD, ST_ORD_DATA, ST_RESULT
    } t_state;

    function automatic logic [SEED_W-1:0] xorshift(input logic [SEED_W-1:0] x);
        logic [SEED_W-1:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    t_state            r_state;
    logic [GW-1:0]     r_clr;
    logic [SEED_W-1:0] r_rng;
    logic [GW-1:0]     r_gidx;
    logic [OAW-1:0]    r_base;
    logic [ZW-1:0]     r_n;
    logic [ZW-1:0]     r_idx;
    logic [CW-1:0]     r_swaps;
    logic [SW-1:0]     r_a;
    logic [SW-1:0]     r_b;
    logic [OAW-1:0]    r_ra;
    logic [OAW-1:0]    r_rb;
    logic [SW-1:0]     r_ta;
    logic              r_is_pick;
    logic [PICK_W-1:0] r_pk;
    logic              r_er;
    logic              r_rs;
    logic              r_ov;
    logic [PICK_W-1:0] r_out_picked;
    logic              r_out_error;
    logic              r_out_resh;

    t_grp_entry        r_gmem [GROUPS];
    t_grp_entry        r_gq;
    logic [SW-1:0]     r_omem [OD];
    logic [SW-1:0]     r_qa;
    logic [SW-1:0]     r_qb;

    logic                    gm_we;
    logic [GW-1:0]           gm_wa;
    t_grp_entry              gm_wd;
    logic                    om_we;
    logic [OAW-1:0]          om_wa;
    logic [SW-1:0]           om_wd;

    logic [SEED_W-1:0]       n_rng;
    logic [PW-1:0]           w_prod;
    logic [SW-1:0]           w_draw;
    logic [GW+GROUP_W-1:0]   w_gext;
    logic [GW-1:0]           w_gidx;
    logic                    w_in_range;
    logic [ZW-1:0]           w_sat;
    logic [SW+PICK_W-1:0]    w_pick_ext;
    logic                    w_accept;

    assign n_rng      = xorshift(r_rng);
    assign w_prod     = PW'(n_rng[SEED_W-1:16]) * PW'(r_n);
    assign w_draw     = w_prod[16+SW-1:16];
    assign w_gext     = {{GW{1'b0}}, i_cmd.group};
    assign w_gidx     = w_gext[GW-1:0];
    assign w_in_range = ({{(32-GROUP_W){1'b0}}, i_cmd.group} < 32'(GROUPS));
    assign w_sat      = ({{(32-SIZE_IN_W){1'b0}}, i_cmd.size} > 32'(SLOTS)) ?
                        ZW'(SLOTS) : ZW'(i_cmd.size);
    assign w_pick_ext = {{PICK_W{1'b0}}, r_qa};
    assign w_accept   = i_cmd.valid && i_cmd.ready;

    assign i_cmd.ready      = (r_state == ST_IDLE);
    assign o_res.valid      = r_ov;
    assign o_res.picked     = r_out_picked;
    assign o_res.error      = r_out_error;
    assign o_res.reshuffled = r_out_resh;

    // group table write port
    always_comb begin
        gm_we = 1'b0;
        gm_wa = r_gidx;
        gm_wd = '0;
        unique case (r_state)
            ST_CLEAR: begin
                gm_we = 1'b1;
                gm_wa = r_clr;
            end
            ST_SET_WR: begin
                gm_we = 1'b1;
                gm_wd = '{size: r_n, count: '0};
            end
            ST_GDEC: begin
                gm_we = (r_gq.size != '0) && (r_gq.count != r_gq.size);
                gm_wd = '{size: r_gq.size, count: r_gq.count + ZW'(1)};
            end
            ST_PICK0: begin
                gm_we = 1'b1;
                gm_wd = '{size: r_n, count: ZW'(1)};
            end
            default: begin
                gm_we = 1'b0;
            end
        endcase
    end

    // order table write port
    always_comb begin
        om_we = 1'b0;
        om_wa = r_ra;
        om_wd = r_qb;
        unique case (r_state)
            ST_INIT: begin
                om_we = 1'b1;
                om_wa = r_base + OAW'(r_idx);
                om_wd = SW'(r_idx);
            end
            ST_SW_WA: begin
                om_we = 1'b1;
                om_wa = r_ra;
                om_wd = r_qb;
            end
            ST_SW_WB: begin
                om_we = 1'b1;
                om_wa = r_rb;
                om_wd = r_ta;
            end
            default: begin
                om_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (gm_we) begin
            r_gmem[gm_wa] <= gm_wd;
        end
        r_gq <= r_gmem[r_gidx];
    end

    always_ff @(posedge i_clk) begin
        if (om_we) begin
            r_omem[om_wa] <= om_wd;
        end
        r_qa <= r_omem[r_ra];
        r_qb <= r_omem[r_rb];
    end

    // random generator, seed load takes precedence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng <= SEED_RESET;
        end else if (i_cfg_we) begin
            // zero seed would lock the generator
            r_rng <= (i_cfg_wdata != '0) ? i_cfg_wdata : SEED_RESET;
        end else if (r_state == ST_DRAW_A || r_state == ST_DRAW_B) begin
            r_rng <= n_rng;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && o_res.ready && (r_state != ST_RESULT)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + GW'(1);
                    if (r_clr == GW'(GROUPS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_gidx    <= w_gidx;
                        r_base    <= OAW'(w_gidx * SLOTS);
                        r_pk      <= '0;
                        r_er      <= !w_in_range && (i_cmd.command == CMD_PICK);
                        r_rs      <= 1'b0;
                        r_is_pick <= (i_cmd.command == CMD_PICK);
                        if (!w_in_range) begin
                            r_state <= ST_RESULT;
                        end else if (i_cmd.command == CMD_PICK) begin
                            r_state <= ST_GRD;
                        end else begin
                            r_n     <= w_sat;
                            r_state <= ST_SET_WR;
                        end
                    end
                end
                ST_SET_WR: begin
                    if (r_n == '0) begin
                        r_state <= ST_RESULT;
                    end else begin
                        r_idx   <= '0;
                        r_rs    <= 1'b1;
                        r_state <= ST_INIT;
                    end
                end
                ST_GRD: begin
                    r_state <= ST_GDEC;
                end
                ST_GDEC: begin
                    priority if (r_gq.size == '0) begin
                        r_er    <= 1'b1;
                        r_state <= ST_RESULT;
                    end else if (r_gq.count == r_gq.size) begin
                        r_n     <= r_gq.size;
                        r_idx   <= '0;
                        r_rs    <= 1'b1;
                        r_state <= ST_INIT;
                    end else begin
                        r_ra    <= r_base + OAW'(r_gq.count);
                        r_state <= ST_ORD_RD;
                    end
                end
                ST_INIT: begin
                    r_idx <= r_idx + ZW'(1);
                    if (r_idx == r_n - ZW'(1)) begin
                        r_swaps <= CW'(r_n * SWAP_FACTOR);
                        r_state <= ST_DRAW_A;
                    end
                end
                ST_DRAW_A: begin
                    r_a     <= w_draw;
                    r_state <= ST_DRAW_B;
                end
                ST_DRAW_B: begin
                    r_b     <= w_draw;
                    r_ra    <= r_base + OAW'(r_a);
                    r_state <= ST_SW_RA;
                end
                ST_SW_RA: begin
                    r_rb    <= r_base + OAW'(r_b);
                    r_state <= ST_SW_RB;
                end
                ST_SW_RB: begin
                    r_state <= ST_SW_WA;
                end
                ST_SW_WA: begin
                    r_ta    <= r_qa;
                    r_state <= ST_SW_WB;
                end
                ST_SW_WB: begin
                    r_swaps <= r_swaps - CW'(1);
                    priority if (r_swaps != CW'(1)) begin
                        r_state <= ST_DRAW_A;
                    end else if (r_is_pick) begin
                        r_state <= ST_PICK0;
                    end else begin
                        r_state <= ST_RESULT;
                    end
                end
                ST_PICK0: begin
                    r_ra    <= r_base;
                    r_state <= ST_ORD_RD;
                end
                ST_ORD_RD: begin
                    r_state <= ST_ORD_DATA;
                end
                ST_ORD_DATA: begin
                    r_pk    <= w_pick_ext[PICK_W-1:0];
                    r_state <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov         <= 1'b1;
                        r_out_picked <= r_pk;
                        r_out_error  <= r_er;
                        r_out_resh   <= r_rs;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
